[rtl/lpbr_pkg.sv]
// ----------------------------------------------------------------------------
// Length-prefixed bit receiver package
// Shared constants and the per-request result type.
// ----------------------------------------------------------------------------
package lpbr_pkg;

    localparam int unsigned BYTE_BITS = 8;

    typedef struct packed {
        logic                 reply_busy;
        logic                 byte_valid;
        logic [BYTE_BITS-1:0] byte_data;
        logic                 message_last;
    } t_result;

endpackage

[rtl/lpbr_ctrl.sv]
// ----------------------------------------------------------------------------
// Length-prefixed bit receiver control
// Holds the sender lock, length header and byte assembly state, and
// computes the result of the request presented this cycle.
// ----------------------------------------------------------------------------
module lpbr_ctrl
    import lpbr_pkg::*;
#(
    parameter int unsigned ID_BITS     = 22,
    parameter int unsigned LENGTH_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [ID_BITS-1:0] i_sender_id,
    input  logic               i_bit_value,
    output t_result            o_result
);

    localparam int unsigned HC_W  = $clog2(LENGTH_BITS + 1);
    localparam int unsigned BIB_W = $clog2(BYTE_BITS);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_MESSAGE
    } t_phase;

    t_phase                 r_phase,         n_phase;
    logic [ID_BITS-1:0]     r_owner_id,      n_owner_id;
    logic [LENGTH_BITS-1:0] r_length,        n_length;
    logic [HC_W-1:0]        r_header_count,  n_header_count;
    logic [BYTE_BITS-1:0]   r_byte_shift,    n_byte_shift;
    logic [BIB_W-1:0]       r_bit_in_byte,   n_bit_in_byte;
    logic [LENGTH_BITS-1:0] r_byte_index,    n_byte_index;

    logic [LENGTH_BITS-1:0] w_length_next;
    logic [BYTE_BITS-1:0]   w_byte_next;
    logic [LENGTH_BITS-1:0] w_index_next;

    assign w_length_next = {r_length[LENGTH_BITS-2:0], i_bit_value};
    assign w_byte_next   = {r_byte_shift[BYTE_BITS-2:0], i_bit_value};
    assign w_index_next  = r_byte_index + LENGTH_BITS'(1);

    always_comb begin
        n_phase        = r_phase;
        n_owner_id     = r_owner_id;
        n_length       = r_length;
        n_header_count = r_header_count;
        n_byte_shift   = r_byte_shift;
        n_bit_in_byte  = r_bit_in_byte;
        n_byte_index   = r_byte_index;
        o_result       = '0;

        case (r_phase)
            PH_HEADER: begin
                if (i_sender_id != r_owner_id) begin
                    o_result.reply_busy = 1'b1;
                end else begin
                    n_length       = w_length_next;
                    n_header_count = r_header_count + HC_W'(1);
                    if (r_header_count == HC_W'(LENGTH_BITS - 1)) begin
                        if (w_length_next == '0) begin
                            o_result.message_last = 1'b1;
                            n_phase               = PH_IDLE;
                        end else begin
                            n_phase       = PH_MESSAGE;
                            n_byte_shift  = '0;
                            n_bit_in_byte = '0;
                            n_byte_index  = '0;
                        end
                    end
                end
            end
            PH_MESSAGE: begin
                if (i_sender_id != r_owner_id) begin
                    o_result.reply_busy = 1'b1;
                end else begin
                    n_byte_shift  = w_byte_next;
                    n_bit_in_byte = r_bit_in_byte + BIB_W'(1);
                    if (r_bit_in_byte == BIB_W'(BYTE_BITS - 1)) begin
                        o_result.byte_valid = 1'b1;
                        o_result.byte_data  = w_byte_next;
                        n_byte_shift        = '0;
                        n_byte_index        = w_index_next;
                        if (w_index_next == r_length) begin
                            o_result.message_last = 1'b1;
                            n_phase               = PH_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_phase        = PH_HEADER;
                n_owner_id     = i_sender_id;
                n_length       = '0;
                n_header_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_owner_id     <= '0;
            r_length       <= '0;
            r_header_count <= '0;
            r_byte_shift   <= '0;
            r_bit_in_byte  <= '0;
            r_byte_index   <= '0;
        end else if (i_fire) begin
            r_phase        <= n_phase;
            r_owner_id     <= n_owner_id;
            r_length       <= n_length;
            r_header_count <= n_header_count;
            r_byte_shift   <= n_byte_shift;
            r_bit_in_byte  <= n_bit_in_byte;
            r_byte_index   <= n_byte_index;
        end
    end

endmodule

[rtl/length_prefixed_bit_receiver_core.sv]
// ----------------------------------------------------------------------------
// Length-prefixed bit receiver core
// Each input request carries one bit from a tagged sender. The first request
// seen while idle locks onto its sender and its bit is dropped. The owner's
// next LENGTH_BITS bits give a byte count, most significant bit first, and
// the bits after that are packed into bytes, most significant bit first.
// Every request produces exactly one output request: a proceed reply to the
// owner, or a busy reply to any other sender. A completed byte rides on the
// owner's reply, and the reply that ends the message is flagged as last.
// A zero count ends the message on the last header bit.
// The output is valid in the cycle after input acceptance, and one request
// per cycle is sustained while the output is not stalled; the single
// output register sets this. Input stays ready while that register is empty
// or being drained, so a receiver stall stalls the input in the same cycle.
// Reset clears the lock and all counters and empties the output register.
// ----------------------------------------------------------------------------
module length_prefixed_bit_receiver_core
    import lpbr_pkg::*;
#(
    parameter int unsigned ID_BITS     = 22,
    parameter int unsigned LENGTH_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [ID_BITS-1:0]   i_sender_id,
    input  logic                 i_bit_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [ID_BITS-1:0]   o_reply_to,
    output logic                 o_reply_busy,
    output logic                 o_byte_valid,
    output logic [BYTE_BITS-1:0] o_byte_data,
    output logic                 o_message_last
);

    logic               w_fire;
    t_result            w_result;
    logic               r_out_valid;
    logic [ID_BITS-1:0] r_reply_to;
    t_result            r_result;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_fire     = i_in_valid && o_in_ready;

    lpbr_ctrl #(
        .ID_BITS     (ID_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_sender_id (i_sender_id),
        .i_bit_value (i_bit_value),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_reply_to <= i_sender_id;
            r_result   <= w_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_reply_to     = r_reply_to;
    assign o_reply_busy   = r_result.reply_busy;
    assign o_byte_valid   = r_result.byte_valid;
    assign o_byte_data    = r_result.byte_data;
    assign o_message_last = r_result.message_last;

endmodule

[rtl/lpbr_checker.sv]
// ----------------------------------------------------------------------------
// Length-prefixed bit receiver checker
// Port-level properties of the receiver core, bound to the top level.
// ----------------------------------------------------------------------------
module lpbr_checker
    import lpbr_pkg::*;
#(
    parameter int unsigned ID_BITS = 22
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [ID_BITS-1:0]   o_reply_to,
    input logic                 o_reply_busy,
    input logic                 o_byte_valid,
    input logic [BYTE_BITS-1:0] o_byte_data,
    input logic                 o_message_last
);

    // A busy reply never carries a byte or ends a message.
    a_busy_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reply_busy |-> !o_byte_valid && !o_message_last)
        else $error("busy reply carries message data");

    // Every accepted request yields a result in the next cycle.
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted request produced no result");

    // A stalled output blocks the input.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while output stalled");

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_reply_to)
            && $stable(o_byte_data) && $stable(o_message_last))
        else $error("stalled result changed");

endmodule

bind length_prefixed_bit_receiver_core lpbr_checker #(
    .ID_BITS (ID_BITS)
) u_lpbr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_reply_to     (o_reply_to),
    .o_reply_busy   (o_reply_busy),
    .o_byte_valid   (o_byte_valid),
    .o_byte_data    (o_byte_data),
    .o_message_last (o_message_last)
);

[tb/sv/length_prefixed_bit_receiver_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Length-prefixed bit receiver core test
// Drives bit requests from tagged senders into the core and checks every
// reply against a cycle-free prediction of the lock, header and byte logic.
// Directed messages cover zero length, extreme ids, extreme bytes and a
// full-scale open length; random messages with interleaved foreign senders
// make up the bulk, under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module length_prefixed_bit_receiver_core_test;
    import lpbr_pkg::*;

    localparam int unsigned ID_W  = 22;
    localparam int unsigned LEN_W = 32;
    localparam logic [ID_W-1:0] ID_MAX = '1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_ITEMS = 1050;

    typedef enum logic [1:0] {
        RX_IDLE    = 2'd0,
        RX_HEADER  = 2'd1,
        RX_PAYLOAD = 2'd2
    } t_rx_phase;

    typedef struct packed {
        logic [ID_W-1:0] reply_to;
        t_result         res;
    } t_reply_exp;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 r_in_valid;
    logic                 o_in_ready;
    logic [ID_W-1:0]      r_sender_id;
    logic                 r_bit_value;
    logic                 o_out_valid;
    logic                 r_out_ready;
    logic [ID_W-1:0]      o_reply_to;
    logic                 o_reply_busy;
    logic                 o_byte_valid;
    logic [BYTE_BITS-1:0] o_byte_data;
    logic                 o_message_last;

    t_reply_exp           pending_replies[$];
    int                   mismatch_count;
    int                   requests_sent;
    int                   burst_left;
    int                   idle_cycles;
    int                   stall_mode;
    int                   stall_left;

    t_rx_phase            rx_phase;
    logic [ID_W-1:0]      rx_owner;
    logic [LEN_W-1:0]     rx_length;
    logic [5:0]           rx_hdr_count;
    logic [7:0]           rx_byte;
    int unsigned          rx_bit_count;
    logic [31:0]          rx_byte_count;

    length_prefixed_bit_receiver_core #(
        .ID_BITS     (ID_W),
        .LENGTH_BITS (LEN_W)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (r_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sender_id    (r_sender_id),
        .i_bit_value    (r_bit_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (r_out_ready),
        .o_reply_to     (o_reply_to),
        .o_reply_busy   (o_reply_busy),
        .o_byte_valid   (o_byte_valid),
        .o_byte_data    (o_byte_data),
        .o_message_last (o_message_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic clear_receiver_state();
        rx_phase      = RX_IDLE;
        rx_owner      = '0;
        rx_length     = '0;
        rx_hdr_count  = '0;
        rx_byte       = '0;
        rx_bit_count  = 0;
        rx_byte_count = '0;
    endtask

    task automatic predict_reply(input logic [ID_W-1:0] sid, input logic bitv);
        t_reply_exp e;
        e = '0;
        e.reply_to = sid;
        if (rx_phase != RX_HEADER && rx_phase != RX_PAYLOAD) begin
            rx_owner     = sid;
            rx_phase     = RX_HEADER;
            rx_length    = '0;
            rx_hdr_count = '0;
        end else if (sid != rx_owner) begin
            e.res.reply_busy = 1'b1;
        end else if (rx_phase == RX_HEADER) begin
            rx_length    = {rx_length[LEN_W-2:0], bitv};
            rx_hdr_count = rx_hdr_count + 6'd1;
            if (rx_hdr_count == LEN_W) begin
                if (rx_length == '0) begin
                    e.res.message_last = 1'b1;
                    clear_receiver_state();
                end else begin
                    rx_phase      = RX_PAYLOAD;
                    rx_byte       = '0;
                    rx_bit_count  = 0;
                    rx_byte_count = '0;
                end
            end
        end else begin
            rx_byte      = {rx_byte[6:0], bitv};
            rx_bit_count = rx_bit_count + 1;
            if (rx_bit_count >= BYTE_BITS) begin
                e.res.byte_valid = 1'b1;
                e.res.byte_data  = rx_byte;
                rx_bit_count     = 0;
                rx_byte          = '0;
                rx_byte_count    = rx_byte_count + 32'd1;
                if (rx_byte_count == rx_length) begin
                    e.res.message_last = 1'b1;
                    clear_receiver_state();
                end
            end
        end
        pending_replies.push_back(e);
    endtask

    // The sender works in bursts; a gap of idle cycles may precede each burst.
    task automatic send_request(input logic [ID_W-1:0] sid, input logic bitv);
        if (burst_left == 0) begin
            burst_left  = $urandom_range(1, 40);
            idle_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (idle_cycles) @(negedge i_clk) r_in_valid <= 1'b0;
        end
        burst_left = burst_left - 1;
        @(negedge i_clk);
        r_in_valid  <= 1'b1;
        r_sender_id <= sid;
        r_bit_value <= bitv;
        do @(posedge i_clk); while (!o_in_ready);
        predict_reply(sid, bitv);
        requests_sent = requests_sent + 1;
    endtask

    task automatic send_owner_bit(input logic [ID_W-1:0] owner, input logic bitv,
                                  input int noise_pct);
        logic [ID_W-1:0] other;
        while ($urandom_range(0, 99) < noise_pct) begin
            other = owner ^ ID_W'($urandom_range(1, int'(ID_MAX)));
            send_request(other, 1'($urandom));
        end
        send_request(owner, bitv);
    endtask

    task automatic send_header(input logic [ID_W-1:0] owner, input logic [LEN_W-1:0] len,
                               input int noise_pct);
        send_request(owner, 1'($urandom));
        for (int i = LEN_W - 1; i >= 0; i--) begin
            send_owner_bit(owner, len[i], noise_pct);
        end
    endtask

    task automatic send_byte(input logic [ID_W-1:0] owner, input logic [7:0] data,
                             input int noise_pct);
        for (int i = 7; i >= 0; i--) begin
            send_owner_bit(owner, data[i], noise_pct);
        end
    endtask

    task automatic test_zero_length();
        send_request('0, 1'b1);
        send_request(ID_MAX, 1'b1);
        for (int i = 0; i < LEN_W; i++) begin
            send_request('0, 1'b0);
        end
    endtask

    task automatic test_extreme_bytes();
        send_header(ID_MAX, 32'd2, 0);
        send_byte(ID_MAX, 8'hFF, 0);
        send_request('0, 1'b0);
        send_byte(ID_MAX, 8'h00, 0);
    endtask

    task automatic test_random_messages();
        logic [ID_W-1:0]  owner;
        logic [LEN_W-1:0] len;
        int               noise_pct;
        int               pick;
        while (requests_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            owner = (pick == 0) ? '0 : (pick == 1) ? ID_MAX : ID_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                len = '0;
            end else if (pick < 90) begin
                len = $urandom_range(1, 3);
            end else begin
                len = $urandom_range(4, 8);
            end
            noise_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
            send_header(owner, len, noise_pct);
            for (int b = 0; b < int'(len); b++) begin
                send_byte(owner, 8'($urandom), noise_pct);
            end
        end
    endtask

    // A full-scale count sets every header bit; the message is left open.
    task automatic test_open_ended_length();
        logic [ID_W-1:0] owner;
        owner = ID_W'($urandom);
        send_header(owner, '1, 15);
        for (int b = 0; b < 4; b++) begin
            send_byte(owner, 8'($urandom), 15);
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(32, 256);
        end else begin
            stall_left = stall_left - 1;
        end
        case (stall_mode)
            0: begin
                r_out_ready <= 1'b1;
            end
            1: begin
                r_out_ready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
                r_out_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                r_out_ready <= (stall_left % 5 < 2);
            end
        endcase
    end

    always @(posedge i_clk) begin
        t_reply_exp e;
        if (i_rst_n && o_out_valid && r_out_ready) begin
            if (pending_replies.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("Unexpected reply: to=%h busy=%b valid=%b data=%h last=%b",
                             o_reply_to, o_reply_busy, o_byte_valid, o_byte_data,
                             o_message_last);
                end
            end else begin
                e = pending_replies.pop_front();
                if (o_reply_to !== e.reply_to || o_reply_busy !== e.res.reply_busy ||
                    o_byte_valid !== e.res.byte_valid || o_byte_data !== e.res.byte_data ||
                    o_message_last !== e.res.message_last) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("Reply mismatch: exp to=%h busy=%b valid=%b data=%h last=%b",
                                 e.reply_to, e.res.reply_busy, e.res.byte_valid,
                                 e.res.byte_data, e.res.message_last);
                        $display("                got to=%h busy=%b valid=%b data=%h last=%b",
                                 o_reply_to, o_reply_busy, o_byte_valid, o_byte_data,
                                 o_message_last);
                    end
                end
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((r_in_valid && o_in_ready) || (o_out_valid && r_out_ready) || !i_rst_n) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        r_in_valid     = 1'b0;
        r_sender_id    = '0;
        r_bit_value    = 1'b0;
        r_out_ready    = 1'b0;
        mismatch_count = 0;
        requests_sent  = 0;
        burst_left     = 0;
        stall_mode     = 0;
        stall_left     = 0;
        clear_receiver_state();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_length();
        test_extreme_bytes();
        test_random_messages();
        test_open_ended_length();

        @(negedge i_clk) r_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
